// ----- sv/mieu_pkg.sv -----
// Package: operation codes, write kinds, store sizes and controller-datapath command and status types.
package mieu_pkg;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SUBU = 6'd2, OP_MULT = 6'd3, OP_MULTU = 6'd4,
    OP_DIV = 6'd5, OP_DIVU = 6'd6, OP_NEGU = 6'd7, OP_NEG = 6'd8, OP_LW = 6'd9,
    OP_LH = 6'd10, OP_LHU = 6'd11, OP_LB = 6'd12, OP_LBU = 6'd13, OP_SW = 6'd14,
    OP_SH = 6'd15, OP_SB = 6'd16, OP_LUI = 6'd17, OP_MFHI = 6'd18, OP_MFLO = 6'd19,
    OP_AND = 6'd20, OP_OR = 6'd21, OP_XOR = 6'd22, OP_NOR = 6'd23, OP_SLT = 6'd24,
    OP_SLTU = 6'd25, OP_SLL = 6'd26, OP_SRL = 6'd27, OP_SRA = 6'd28, OP_BEQ = 6'd29,
    OP_BNE = 6'd30, OP_BEQZ = 6'd31, OP_BNEZ = 6'd32, OP_BLEZ = 6'd33, OP_BLTZ = 6'd34,
    OP_BGEZ = 6'd35, OP_BGTZ = 6'd36, OP_J = 6'd37, OP_JAL = 6'd38, OP_NOP = 6'd39,
    OP_MOVE = 6'd40, OP_TEQ = 6'd41, OP_TGE = 6'd42, OP_TGEU = 6'd43, OP_TLT = 6'd44,
    OP_TLTU = 6'd45, OP_TNE = 6'd46
  } op_t;

  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_RD   = 2'd1;
  localparam logic [1:0] WK_RA   = 2'd2;
  localparam logic [1:0] WK_MEM  = 2'd3;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam int DivSteps = 32;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  typedef struct packed {
    logic load;      // capture a new item
    logic mul_step;  // multiply step after decode: write HI/LO
    logic div_start; // set up divider
    logic div_step;  // one quotient bit
    logic div_done;  // write HI/LO from divider
    logic finish;    // form the result and advance PC
    logic out_take;  // result was taken downstream
  } ctl_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
  } ctl_sts_t;

endpackage

// ----- sv/mieu_ctrl.sv -----
// Controller: sequences one instruction through capture, multiply, divide and output.
module mieu_ctrl
  import mieu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DEC = 6'b000010, S_MUL = 6'b000100,
    S_DIV  = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE) || (state_r == S_OUT && out_tready);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_take = out_tvalid && out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_mul) begin
          state_nxt = S_MUL;
        end else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.div_done = sts.is_div;
        cmd.finish   = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          if (in_tvalid) begin
            cmd.load  = 1'b1;
            state_nxt = S_DEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_tready && in_tvalid) else $error("load without request");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

endmodule

// ----- sv/mieu_dp.sv -----
// Datapath: ALU, branch unit, multiplier, radix-2 divider, PC/HI/LO and result register.
module mieu_dp
  import mieu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [5:0]  in_op,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  input  logic [31:0] in_c,
  input  ctl_cmd_t    cmd,
  output ctl_sts_t    sts,
  output logic [31:0] res_value,
  output logic [1:0]  res_kind,
  output logic [1:0]  res_size,
  output logic [31:0] res_npc,
  output logic        res_trap,
  output logic [31:0] res_code
);

  logic [5:0]  op_r;
  logic [31:0] a_r, b_r, c_r;
  logic [31:0] pc_r, pc_nxt, hi_r, hi_nxt, lo_r, lo_nxt;
  logic [63:0] prod_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic        neg_q_r, neg_r_r;
  logic [DivCntW-1:0] cnt_r;
  logic [31:0] value_r, npc_r, code_r;
  logic [1:0]  kind_r, size_r;
  logic        trap_r;

  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] v, npc;
  logic [1:0]  kind, size;
  logic        trap, br_valid, br_taken;
  logic [31:0] br_tgt;
  logic        lt_s, lt_u;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  assign sts.is_mul   = (op_r == OP_MULT) || (op_r == OP_MULTU);
  assign sts.is_div   = (op_r == OP_DIV) || (op_r == OP_DIVU);
  assign sts.div_last = (cnt_r == DivCntW'(1));

  assign lt_s = $signed(a_r) < $signed(b_r);
  assign lt_u = a_r < b_r;

  // one 33x33 signed multiplier serves both MULT and MULTU
  assign mul_a = $signed({(op_r == OP_MULT) && a_r[31], a_r});
  assign mul_b = $signed({(op_r == OP_MULT) && b_r[31], b_r});
  assign mul_p = mul_a * mul_b;

  // one restoring-division step
  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      a_r  <= in_a;
      b_r  <= in_b;
      c_r  <= in_c;
    end
    if (sts.is_mul && !cmd.mul_step) begin
      prod_r <= mul_p[63:0];
    end
    if (cmd.div_start) begin
      neg_q_r <= (op_r == OP_DIV) && (a_r[31] ^ b_r[31]);
      neg_r_r <= (op_r == OP_DIV) && a_r[31];
      quo_r   <= ((op_r == OP_DIV) && a_r[31]) ? 32'd0 - a_r : a_r;
      dvs_r   <= ((op_r == OP_DIV) && b_r[31]) ? 32'd0 - b_r : b_r;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      if (!trial[32]) rem_r <= trial[31:0];
      else            rem_r <= rem_sh;
      quo_r <= {quo_r[30:0], ~trial[32]};
    end
    if (cmd.finish) begin
      value_r <= v;
      kind_r  <= kind;
      size_r  <= size;
      npc_r   <= npc;
      trap_r  <= trap;
      code_r  <= trap ? c_r : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.div_start) cnt_r <= DivCntW'(DivSteps);
    else if (cmd.div_step)  cnt_r <= cnt_r - DivCntW'(1);
  end

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (cmd.mul_step) begin
      hi_nxt = prod_r[63:32];
      lo_nxt = prod_r[31:0];
    end else if (cmd.div_done && dvs_r != 32'd0) begin
      lo_nxt = neg_q_r ? 32'd0 - quo_r : quo_r;
      hi_nxt = neg_r_r ? 32'd0 - rem_r : rem_r;
    end
  end

  always_comb begin
    v = '0; kind = WK_NONE; size = SZ_BYTE; trap = 1'b0;
    br_valid = 1'b0; br_taken = 1'b0; br_tgt = b_r;
    npc = pc_r + 32'd4;
    unique case (op_r)
      OP_ADD:                   begin v = a_r + b_r; kind = WK_RD; end
      OP_SUB, OP_SUBU:          begin v = a_r - b_r; kind = WK_RD; end
      OP_NEGU, OP_NEG:          begin v = 32'd0 - a_r; kind = WK_RD; end
      OP_LW, OP_MOVE:           begin v = a_r; kind = WK_RD; end
      OP_LH:  begin v = {{16{a_r[15]}}, a_r[15:0]}; kind = WK_RD; end
      OP_LHU: begin v = {16'd0, a_r[15:0]}; kind = WK_RD; end
      OP_LB:  begin v = {{24{a_r[7]}}, a_r[7:0]}; kind = WK_RD; end
      OP_LBU: begin v = {24'd0, a_r[7:0]}; kind = WK_RD; end
      OP_SW:  begin v = a_r; kind = WK_MEM; size = SZ_WORD; end
      OP_SH:  begin v = {16'd0, a_r[15:0]}; kind = WK_MEM; size = SZ_HALF; end
      OP_SB:  begin v = {24'd0, a_r[7:0]}; kind = WK_MEM; size = SZ_BYTE; end
      OP_LUI:  begin v = {a_r[15:0], 16'd0}; kind = WK_RD; end
      OP_MFHI: begin v = hi_r; kind = WK_RD; end
      OP_MFLO: begin v = lo_r; kind = WK_RD; end
      OP_AND:  begin v = a_r & b_r; kind = WK_RD; end
      OP_OR:   begin v = a_r | b_r; kind = WK_RD; end
      OP_XOR:  begin v = a_r ^ b_r; kind = WK_RD; end
      OP_NOR:  begin v = ~(a_r | b_r); kind = WK_RD; end
      OP_SLT:  begin v = {31'd0, lt_s}; kind = WK_RD; end
      OP_SLTU: begin v = {31'd0, lt_u}; kind = WK_RD; end
      OP_SLL:  begin v = a_r << b_r[4:0]; kind = WK_RD; end
      OP_SRL:  begin v = a_r >> b_r[4:0]; kind = WK_RD; end
      OP_SRA:  begin v = 32'($signed(a_r) >>> b_r[4:0]); kind = WK_RD; end
      OP_BEQ:  begin br_valid = 1'b1; br_taken = (a_r == b_r); br_tgt = c_r; end
      OP_BNE:  begin br_valid = 1'b1; br_taken = (a_r != b_r); br_tgt = c_r; end
      OP_BEQZ: begin br_valid = 1'b1; br_taken = (a_r == 32'd0); end
      OP_BNEZ: begin br_valid = 1'b1; br_taken = (a_r != 32'd0); end
      OP_BLEZ: begin br_valid = 1'b1; br_taken = (a_r == 32'd0) || a_r[31]; end
      OP_BLTZ: begin br_valid = 1'b1; br_taken = a_r[31]; end
      OP_BGEZ: begin br_valid = 1'b1; br_taken = !a_r[31]; end
      OP_BGTZ: begin br_valid = 1'b1; br_taken = (a_r != 32'd0) && !a_r[31]; end
      OP_J:    npc = a_r;
      OP_JAL:  begin v = pc_r + 32'd8; kind = WK_RA; npc = a_r; end
      OP_TEQ:  trap = (a_r == b_r);
      OP_TGE:  trap = !lt_s;
      OP_TGEU: trap = !lt_u;
      OP_TLT:  trap = lt_s;
      OP_TLTU: trap = lt_u;
      OP_TNE:  trap = (a_r != b_r);
      default: ;
    endcase
    if (br_valid) npc = br_taken ? br_tgt : pc_r + 32'd8;
  end

  assign pc_nxt = cmd.finish ? npc : pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign res_value = value_r;
  assign res_kind  = kind_r;
  assign res_size  = size_r;
  assign res_npc   = npc_r;
  assign res_trap  = trap_r;
  assign res_code  = code_r;

  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(pc_r)) else $error("PC moved without an instruction");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> cnt_r != '0) else $error("divider stepped past its end");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    !trap_r |-> code_r == 32'd0) else $error("trap code without trap");

endmodule

// ----- sv/mips_integer_execute_unit.sv -----
// Top level: MIPS32 integer execute unit with stream input and result channels.
// Sequence: most instructions go from the accepted request through decode to the result,
// MULT/MULTU through decode (registered 32x32 product), HI/LO write and finish, and
// DIV/DIVU through setup, 32 steps of one-bit restoring division and finish.
// Throughput: one instruction in flight; a new request is taken in the cycle the result leaves.
// Reset: synchronous active-low rst_n clears PC, HI, LO, the divide counter and the controller.
module mips_integer_execute_unit
  import mieu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [5:0] operation, [37:6] first_value, [69:38] second_value, [101:70] third_value
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] result_value, [33:32] write_kind, [35:34] store_size, [67:36] next_pc,
  // [68] trap_taken, [100:69] trap_code
  output logic [103:0] out_tdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic [31:0] res_value, res_npc, res_code;
  logic [1:0]  res_kind, res_size;
  logic        res_trap;

  // Controller holds the one-hot sequence; datapath does the work.
  mieu_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );

  mieu_dp u_dp (
    .clk, .rst_n,
    .in_op (in_tdata[5:0]),
    .in_a  (in_tdata[37:6]),
    .in_b  (in_tdata[69:38]),
    .in_c  (in_tdata[101:70]),
    .cmd, .sts,
    .res_value, .res_kind, .res_size, .res_npc, .res_trap, .res_code
  );

  // Pack the result request; pad to whole bytes.
  assign out_tdata = {3'd0, res_code, res_trap, res_npc, res_size, res_kind, res_value};

endmodule
